[hw/rtl/asmc_pkg.sv]
// Shared constants, command and status types, and helpers for the accumulator stack machine.
package asmc_pkg;

  // Storage sizes.
  localparam int unsigned VAR_DEPTH   = 256;
  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned PROG_DEPTH  = 256;

  // Derived widths.
  localparam int unsigned VAR_AW = $clog2(VAR_DEPTH);
  localparam int unsigned STK_AW = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IP_W   = $clog2(PROG_DEPTH);

  // The clearing pass after reset covers the larger of the two memories.
  localparam int unsigned CLR_DEPTH = (VAR_DEPTH > STACK_DEPTH) ? VAR_DEPTH : STACK_DEPTH;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  // Depths as 17-bit values for the index reduction helper.
  localparam logic [16:0] VAR_DEPTH_M  = 17'(VAR_DEPTH);
  localparam logic [16:0] PROG_DEPTH_M = 17'(PROG_DEPTH);

  // Stream payload widths.
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 80;

  // Opcodes.
  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_SUB    = 5'd1;
  localparam logic [4:0] OP_MULT   = 5'd2;
  localparam logic [4:0] OP_DIV    = 5'd3;
  localparam logic [4:0] OP_LOAD   = 5'd4;
  localparam logic [4:0] OP_STORE  = 5'd5;
  localparam logic [4:0] OP_COPY   = 5'd6;
  localparam logic [4:0] OP_READ   = 5'd7;
  localparam logic [4:0] OP_WRITE  = 5'd8;
  localparam logic [4:0] OP_STOP   = 5'd9;
  localparam logic [4:0] OP_NOOP   = 5'd10;
  localparam logic [4:0] OP_BR     = 5'd11;
  localparam logic [4:0] OP_BRNEG  = 5'd12;
  localparam logic [4:0] OP_BRZNEG = 5'd13;
  localparam logic [4:0] OP_BRPOS  = 5'd14;
  localparam logic [4:0] OP_BRZPOS = 5'd15;
  localparam logic [4:0] OP_BRZERO = 5'd16;
  localparam logic [4:0] OP_PUSH   = 5'd17;
  localparam logic [4:0] OP_POP    = 5'd18;
  localparam logic [4:0] OP_STACKW = 5'd19;
  localparam logic [4:0] OP_STACKR = 5'd20;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_RANGE     = 3'd3;
  localparam logic [2:0] ERR_DIV_ZERO  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // write zero at the sweep address and advance it
    logic capture;   // latch the accepted request
    logic decode;    // variable write or variable read
    logic execute;   // carry out the instruction
    logic acc_div;   // load the quotient into the accumulator
    logic acc_stk;   // load the stack read data into the accumulator
    logic out_load;  // fill the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;   // sweep address is at the last entry
    logic halted;     // machine has stopped
    logic item_init;  // captured request is a variable initialization
    logic exec_div;   // instruction needs the iterative divider
    logic exec_stkr;  // instruction needs a stack read
    logic div_done;   // divider has finished
  } ctrl_stat_t;

  // Reduces a byte modulo m by shifted compare and subtract.
  function automatic logic [15:0] mod_byte(input logic [7:0] x, input logic [16:0] m);
    logic [24:0] r;
    logic [24:0] mk;
    r = {17'd0, x};
    for (int k = 7; k >= 0; k--) begin
      mk = {8'd0, m} << k;
      if (r >= mk) begin
        r = r - mk;
      end
    end
    return r[15:0];
  endfunction

endpackage

[hw/rtl/accumulator_stack_machine_core.sv]
// Top level of the accumulator stack machine: stream ports, controller and datapath.
//
// Usage: each request on the slave stream is one decoded instruction (tuser = 0) or one
// variable initialization (tuser = 1). Every request yields exactly one result on the
// master stream, carrying the next instruction address, the accumulator, the halt flag,
// the error code and, when tuser is 1, a value emitted by WRITE.
// Sequencing: one request is in flight at a time. A request passes through capture,
// decode and execute; an initialization or any request after a halt skips execute, a
// stack read adds a stack read step, and a divide waits for the radix-2 divider, which
// yields one quotient bit per cycle. The output register then takes the result.
// Reset: the machine state clears at once; then a clearing pass over 1024 addresses (the
// larger memory depth) zeroes the variable and stack memories, and tready stays low
// until it ends.
// Stalls: the output register holds a result until the receiver takes it; the next
// request is still accepted and worked on, and waits only at the output register.
module accumulator_stack_machine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[4:0], operand_a[12:5], operand_b[20:13], target[28:21], data_value[60:29], zero
  input  logic [63:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_ip[7:0], write_value[39:8], halted[40], error_code[43:41], acc_value[75:44], zero
  output logic [79:0] m_axis_tdata,
  // write_valid[0]
  output logic        m_axis_tuser
);

  asmc_pkg::ctrl_cmd_t  cmd;
  asmc_pkg::ctrl_stat_t st;

  // Sequencing.
  asmc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd),
    .st_i      (st)
  );

  // Machine state and storage.
  asmc_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .st_o      (st),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser)
  );

endmodule

[hw/rtl/asmc_div.sv]
// Radix-2 restoring signed divider that truncates toward zero, one quotient bit a cycle.
module asmc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [32:0] rem_sh;

  // One shift and subtract step per cycle while busy.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[31:0], quo_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = '0;
      quo_d  = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dvs_d  = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      neg_d  = dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

[hw/rtl/asmc_dpath.sv]
// Datapath: accumulator, instruction pointer, variable and stack memories, output register.
module asmc_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  asmc_pkg::ctrl_cmd_t             cmd_i,
  output asmc_pkg::ctrl_stat_t            st_o,
  input  logic [asmc_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  logic                            s_tuser_i,
  output logic [asmc_pkg::M_TDATA_W-1:0]  m_tdata_o,
  output logic                            m_tuser_o
);

  // Memories.
  logic [31:0] var_mem [asmc_pkg::VAR_DEPTH];
  logic [31:0] stk_mem [asmc_pkg::STACK_DEPTH];

  // Captured request.
  logic                        init_q;
  logic [4:0]                  op_q;
  logic [asmc_pkg::VAR_AW-1:0] a_q;
  logic [asmc_pkg::VAR_AW-1:0] b_q;
  logic [asmc_pkg::IP_W-1:0]   tgt_q;
  logic [31:0]                 dv_q;

  // Machine state.
  logic [31:0]                 acc_q, acc_d;
  logic [asmc_pkg::IP_W-1:0]   ip_q, ip_d;
  logic                        halt_q, halt_d;
  logic [2:0]                  err_q, err_d;
  logic [asmc_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        wv_q, wv_d;
  logic [31:0]                 wval_q, wval_d;
  logic [asmc_pkg::CLR_W-1:0]  clr_q;

  // Memory read data.
  logic [31:0] var_rd_q;
  logic [31:0] stk_rd_q;

  // Output register.
  logic [7:0]  out_ip_q;
  logic        out_wv_q;
  logic [31:0] out_wval_q;
  logic        out_halt_q;
  logic [2:0]  out_err_q;
  logic [31:0] out_acc_q;

  // Combinational helpers.
  logic [15:0]                 a_mod, b_mod, tgt_mod;
  logic [asmc_pkg::VAR_AW-1:0] var_ra;
  logic                        var_we;
  logic [asmc_pkg::VAR_AW-1:0] var_wa;
  logic [31:0]                 var_wd;
  logic                        stk_we;
  logic [asmc_pkg::STK_AW-1:0] stk_wa;
  logic [31:0]                 stk_wd;
  logic [31:0]                 cnt_ext;
  logic [31:0]                 loc_full;
  logic [asmc_pkg::STK_AW-1:0] loc;
  logic                        loc_ok;
  logic [asmc_pkg::IP_W-1:0]   ip_inc;
  logic [asmc_pkg::IP_W-1:0]   nip;
  logic [31:0]                 prod;
  logic [asmc_pkg::IP_W+7:0]   ip_ext;
  logic                        clr_var_ok;
  logic                        clr_stk_ok;
  logic                        div_done;
  logic [31:0]                 div_quo;

  // Index reduction of the incoming operands.
  assign a_mod   = asmc_pkg::mod_byte(s_tdata_i[12:5], asmc_pkg::VAR_DEPTH_M);
  assign b_mod   = asmc_pkg::mod_byte(s_tdata_i[20:13], asmc_pkg::VAR_DEPTH_M);
  assign tgt_mod = asmc_pkg::mod_byte(s_tdata_i[28:21], asmc_pkg::PROG_DEPTH_M);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      init_q <= s_tuser_i;
      op_q   <= s_tdata_i[4:0];
      a_q    <= a_mod[asmc_pkg::VAR_AW-1:0];
      b_q    <= b_mod[asmc_pkg::VAR_AW-1:0];
      tgt_q  <= tgt_mod[asmc_pkg::IP_W-1:0];
      dv_q   <= s_tdata_i[60:29];
    end
  end

  // Stack element address, counted down from the top by the variable value.
  assign cnt_ext  = 32'(cnt_q);
  assign loc_ok   = !var_rd_q[31] && (var_rd_q < cnt_ext);
  assign loc_full = cnt_ext - 32'd1 - var_rd_q;
  assign loc      = loc_full[asmc_pkg::STK_AW-1:0];

  // Next sequential instruction address.
  assign ip_inc = (ip_q == asmc_pkg::IP_W'(asmc_pkg::PROG_DEPTH - 1)) ? '0 : ip_q + 1'b1;

  assign prod       = acc_q * var_rd_q;
  assign var_ra     = (op_q == asmc_pkg::OP_COPY) ? b_q : a_q;
  assign clr_var_ok = 32'(clr_q) < 32'(asmc_pkg::VAR_DEPTH);
  assign clr_stk_ok = 32'(clr_q) < 32'(asmc_pkg::STACK_DEPTH);

  // Instruction execution and memory write selection.
  always_comb begin
    acc_d  = acc_q;
    ip_d   = ip_q;
    halt_d = halt_q;
    err_d  = err_q;
    cnt_d  = cnt_q;
    wv_d   = wv_q;
    wval_d = wval_q;
    var_we = 1'b0;
    var_wa = a_q;
    var_wd = dv_q;
    stk_we = 1'b0;
    stk_wa = loc;
    stk_wd = acc_q;
    nip    = ip_inc;
    if (cmd_i.clear) begin
      var_we = clr_var_ok;
      var_wa = clr_q[asmc_pkg::VAR_AW-1:0];
      var_wd = '0;
      stk_we = clr_stk_ok;
      stk_wa = clr_q[asmc_pkg::STK_AW-1:0];
      stk_wd = '0;
    end
    if (cmd_i.decode) begin
      wv_d   = 1'b0;
      wval_d = '0;
      if (!halt_q && init_q) begin
        var_we = 1'b1;
      end
    end
    if (cmd_i.execute) begin
      case (op_q)
        asmc_pkg::OP_ADD:   acc_d = acc_q + var_rd_q;
        asmc_pkg::OP_SUB:   acc_d = acc_q - var_rd_q;
        asmc_pkg::OP_MULT:  acc_d = prod;
        asmc_pkg::OP_DIV: begin
          if (var_rd_q == 32'd0) begin
            halt_d = 1'b1;
            err_d  = asmc_pkg::ERR_DIV_ZERO;
          end
        end
        asmc_pkg::OP_LOAD:  acc_d = var_rd_q;
        asmc_pkg::OP_STORE: begin
          var_we = 1'b1;
          var_wd = acc_q;
        end
        asmc_pkg::OP_COPY: begin
          var_we = 1'b1;
          var_wd = var_rd_q;
        end
        asmc_pkg::OP_READ:  var_we = 1'b1;
        asmc_pkg::OP_WRITE: begin
          wv_d   = 1'b1;
          wval_d = var_rd_q;
        end
        asmc_pkg::OP_STOP:  halt_d = 1'b1;
        asmc_pkg::OP_BR:    nip = tgt_q;
        asmc_pkg::OP_BRNEG: begin
          if (acc_q[31]) nip = tgt_q;
        end
        asmc_pkg::OP_BRZNEG: begin
          if (acc_q[31] || (acc_q == 32'd0)) nip = tgt_q;
        end
        asmc_pkg::OP_BRPOS: begin
          if (!acc_q[31] && (acc_q != 32'd0)) nip = tgt_q;
        end
        asmc_pkg::OP_BRZPOS: begin
          if (!acc_q[31]) nip = tgt_q;
        end
        asmc_pkg::OP_BRZERO: begin
          if (acc_q == 32'd0) nip = tgt_q;
        end
        asmc_pkg::OP_PUSH: begin
          if (cnt_q >= asmc_pkg::CNT_W'(asmc_pkg::STACK_DEPTH)) begin
            halt_d = 1'b1;
            err_d  = asmc_pkg::ERR_OVERFLOW;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        asmc_pkg::OP_POP: begin
          if (cnt_q == '0) begin
            halt_d = 1'b1;
            err_d  = asmc_pkg::ERR_UNDERFLOW;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        asmc_pkg::OP_STACKW: begin
          if (loc_ok) begin
            stk_we = 1'b1;
          end else begin
            halt_d = 1'b1;
            err_d  = asmc_pkg::ERR_RANGE;
          end
        end
        asmc_pkg::OP_STACKR: begin
          if (!loc_ok) begin
            halt_d = 1'b1;
            err_d  = asmc_pkg::ERR_RANGE;
          end
        end
        default: ;
      endcase
      if (!halt_d) begin
        ip_d = nip;
      end
    end
    if (cmd_i.acc_div) begin
      acc_d = div_quo;
    end
    if (cmd_i.acc_stk) begin
      acc_d = stk_rd_q;
    end
  end

  // Machine state registers and sweep address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      ip_q   <= '0;
      halt_q <= 1'b0;
      err_q  <= asmc_pkg::ERR_NONE;
      cnt_q  <= '0;
      wv_q   <= 1'b0;
      wval_q <= '0;
      clr_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      ip_q   <= ip_d;
      halt_q <= halt_d;
      err_q  <= err_d;
      cnt_q  <= cnt_d;
      wv_q   <= wv_d;
      wval_q <= wval_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Variable memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (var_we) begin
      var_mem[var_wa] <= var_wd;
    end
    if (cmd_i.decode) begin
      var_rd_q <= var_mem[var_ra];
    end
  end

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (cmd_i.execute) begin
      stk_rd_q <= stk_mem[loc];
    end
  end

  // Iterative divider.
  asmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.execute && st_o.exec_div),
    .dividend_i (acc_q),
    .divisor_i  (var_rd_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Output register.
  assign ip_ext = {8'd0, ip_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ip_q   <= ip_ext[7:0];
      out_wv_q   <= wv_q;
      out_wval_q <= wval_q;
      out_halt_q <= halt_q;
      out_err_q  <= err_q;
      out_acc_q  <= acc_q;
    end
  end

  assign m_tdata_o = {4'd0, out_acc_q, out_err_q, out_halt_q, out_wval_q, out_ip_q};
  assign m_tuser_o = out_wv_q;

  // Status to the controller.
  always_comb begin
    st_o.clr_done  = (clr_q == asmc_pkg::CLR_W'(asmc_pkg::CLR_DEPTH - 1));
    st_o.halted    = halt_q;
    st_o.item_init = init_q;
    st_o.exec_div  = (op_q == asmc_pkg::OP_DIV) && (var_rd_q != 32'd0);
    st_o.exec_stkr = (op_q == asmc_pkg::OP_STACKR) && loc_ok;
    st_o.div_done  = div_done;
  end

  // Once stopped, the machine stays stopped.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared after a stop");

  // A recorded error always comes with a stop.
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != asmc_pkg::ERR_NONE) |-> halt_q)
    else $error("error code set without halt");

  // The stack count never passes the stack depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= asmc_pkg::CNT_W'(asmc_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

endmodule

[hw/rtl/asmc_ctrl.sv]
// Controller FSM: sequences clearing, decode, execute, divide, stack read, output register.
module asmc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic                  m_ready_i,
  output logic                  m_valid_o,
  output asmc_pkg::ctrl_cmd_t   cmd_o,
  input  asmc_pkg::ctrl_stat_t  st_i
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_STKRD  = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || m_ready_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (st_i.halted || st_i.item_init) begin
          state_d = S_RESP;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        if (st_i.exec_div) begin
          state_d = S_DIV;
        end else if (st_i.exec_stkr) begin
          state_d = S_STKRD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_DIV: begin
        if (st_i.div_done) begin
          cmd_o.acc_div = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_STKRD: begin
        cmd_o.acc_stk = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid follows loads and completed output requests.
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

  // The divide state is left only when the divider reports completion.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !st_i.div_done) |=> (state_q == S_DIV))
    else $error("left divide state before quotient was ready");

  // A pending result is never overwritten before it is taken.
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_ready_i))
    else $error("output register loaded while holding an untaken result");

endmodule

[tb/asmc_checker.sv]
// Checker for the accumulator stack machine: predicts each result and compares it with the block.
`timescale 1ns / 100ps

module asmc_checker
  import asmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [63:0] req_data_i,
  input  logic        req_user_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [79:0] rsp_data_i,
  input  logic        rsp_user_i,
  output int          mismatch_count_o,
  output int          outstanding_o,
  output int          results_o,
  output int          writes_o
);

  // One result of the machine, as the block reports it.
  typedef struct packed {
    logic [IP_W-1:0] next_ip;
    logic            write_valid;
    logic [31:0]     write_value;
    logic            halted;
    logic [2:0]      error_code;
    logic [31:0]     acc_value;
  } step_result_t;

  // Shadow copy of the machine state.
  logic [31:0]      acc_q;
  logic [IP_W-1:0]  ip_q;
  logic [31:0]      var_mem [VAR_DEPTH];
  logic [31:0]      stk_mem [STACK_DEPTH];
  logic [CNT_W-1:0] stk_cnt;
  logic             halt_q;
  logic [2:0]       err_q;

  step_result_t step_result_q[$];
  int           mismatch_cnt;
  int           result_cnt;
  int           write_cnt;

  assign mismatch_count_o = mismatch_cnt;
  assign outstanding_o    = step_result_q.size();
  assign results_o        = result_cnt;
  assign writes_o         = write_cnt;

  // Stops the machine with the given error code.
  function automatic void raise_fault(logic [2:0] code);
    err_q  = code;
    halt_q = 1'b1;
  endfunction

  // Checks a signed stack offset against the current depth and gives the element address.
  function automatic logic stack_slot(logic [31:0] offset, output int slot);
    int off;
    off  = $signed(offset);
    slot = 0;
    if (off < 0 || off >= int'(stk_cnt)) begin
      return 1'b0;
    end
    slot = int'(stk_cnt) - 1 - off;
    return 1'b1;
  endfunction

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic step_result_t execute_request(logic cmd, logic [63:0] data);
    logic [4:0]          op;
    logic [VAR_AW-1:0]   ia;
    logic [VAR_AW-1:0]   ib;
    logic [IP_W-1:0]     tgt;
    logic [IP_W-1:0]     nip;
    logic [31:0]         dv;
    logic [31:0]         va;
    logic signed [31:0]  acc_s;
    longint              quo;
    int                  slot;
    step_result_t        res;
    op  = data[4:0];
    ia  = VAR_AW'(int'(data[12:5]) % VAR_DEPTH);
    ib  = VAR_AW'(int'(data[20:13]) % VAR_DEPTH);
    tgt = IP_W'(int'(data[28:21]) % PROG_DEPTH);
    dv  = data[60:29];
    res.write_valid = 1'b0;
    res.write_value = '0;
    if (!halt_q) begin
      if (cmd) begin
        var_mem[ia] = dv;
      end else begin
        va    = var_mem[ia];
        acc_s = acc_q;
        nip   = IP_W'((int'(ip_q) + 1) % PROG_DEPTH);
        case (op)
          OP_ADD:    acc_q = acc_q + va;
          OP_SUB:    acc_q = acc_q - va;
          OP_MULT:   acc_q = acc_q * va;
          OP_DIV: begin
            if (va == '0) begin
              raise_fault(ERR_DIV_ZERO);
            end else begin
              // Done in 64 bits so that the most negative value over minus one wraps.
              quo   = longint'(acc_s) / longint'($signed(va));
              acc_q = quo[31:0];
            end
          end
          OP_LOAD:   acc_q = va;
          OP_STORE:  var_mem[ia] = acc_q;
          OP_COPY:   var_mem[ia] = var_mem[ib];
          OP_READ:   var_mem[ia] = dv;
          OP_WRITE: begin
            res.write_valid = 1'b1;
            res.write_value = va;
          end
          OP_STOP:   halt_q = 1'b1;
          OP_BR:     nip = tgt;
          OP_BRNEG:  if (acc_s < 0) nip = tgt;
          OP_BRZNEG: if (acc_s <= 0) nip = tgt;
          OP_BRPOS:  if (acc_s > 0) nip = tgt;
          OP_BRZPOS: if (acc_s >= 0) nip = tgt;
          OP_BRZERO: if (acc_s == 0) nip = tgt;
          OP_PUSH: begin
            if (int'(stk_cnt) >= STACK_DEPTH) raise_fault(ERR_OVERFLOW);
            else stk_cnt = stk_cnt + 1'b1;
          end
          OP_POP: begin
            if (stk_cnt == '0) raise_fault(ERR_UNDERFLOW);
            else stk_cnt = stk_cnt - 1'b1;
          end
          OP_STACKW: begin
            if (stack_slot(va, slot)) stk_mem[slot] = acc_q;
            else raise_fault(ERR_RANGE);
          end
          OP_STACKR: begin
            if (stack_slot(va, slot)) acc_q = stk_mem[slot];
            else raise_fault(ERR_RANGE);
          end
          // NOOP and the unused opcodes change nothing.
          default: ;
        endcase
        // A halting instruction leaves the pointer on itself.
        if (!halt_q) begin
          ip_q = nip;
        end
      end
    end
    res.next_ip    = ip_q;
    res.halted     = halt_q;
    res.error_code = err_q;
    res.acc_value  = acc_q;
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
    end
  endfunction

  // Watch both streams; results are compared before a new request is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t want;
    if (!rst_ni) begin
      acc_q   = '0;
      ip_q    = '0;
      stk_cnt = '0;
      halt_q  = 1'b0;
      err_q   = ERR_NONE;
      for (int i = 0; i < VAR_DEPTH; i++) var_mem[i] = '0;
      for (int i = 0; i < STACK_DEPTH; i++) stk_mem[i] = '0;
      step_result_q.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        result_cnt++;
        if (rsp_user_i === 1'b1) write_cnt++;
        if (step_result_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with no request waiting, expected none, actual 0x%020h/%b",
                   $time, rsp_data_i, rsp_user_i);
        end else begin
          want = step_result_q.pop_front();
          check_field("next_ip", 32'(want.next_ip), 32'(rsp_data_i[7:0]));
          check_field("write_valid", 32'(want.write_valid), 32'(rsp_user_i));
          check_field("write_value", want.write_value, rsp_data_i[39:8]);
          check_field("halted", 32'(want.halted), 32'(rsp_data_i[40]));
          check_field("error_code", 32'(want.error_code), 32'(rsp_data_i[43:41]));
          check_field("acc_value", want.acc_value, rsp_data_i[75:44]);
        end
      end
      if (req_valid_i && req_ready_i) begin
        step_result_q.push_back(execute_request(req_user_i, req_data_i));
      end
    end
  end

endmodule

[tb/tb_accumulator_stack_machine_core.sv]
// Testbench top for the accumulator stack machine: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_accumulator_stack_machine_core;
  import asmc_pkg::*;

  // Run sizing: about 650 requests. Even with divides and long stalls on both sides
  // the slowest correct run stays well below a quarter of this limit.
  localparam int ITEM_GOAL       = 650;
  localparam int POST_HALT_ITEMS = 6;
  localparam int DRAIN_CYCLES    = 48;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int STACK_SOFT_CAP  = 48;

  // Variables kept for divisors and stack offsets; random writes never target them.
  localparam logic [7:0] DIVISOR_VAR = 8'hD1;
  localparam logic [7:0] OFFSET_VAR  = 8'h2E;
  localparam logic [4:0] OP_MAX_CODE = '1;

  // Ways in which the run finally stops the machine. An overflow would need a full
  // stack of pushes, far more requests than the whole run, so it is not among them.
  typedef enum int {
    END_STOP,
    END_UNDERFLOW,
    END_RANGE,
    END_DIV_ZERO
  } halt_kind_e;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  int mismatch_count;
  int outstanding;
  int results_seen;
  int writes_seen;
  int cycle_cnt     = 0;
  int sent_count    = 0;
  int random_count  = 0;
  int stk_depth     = 0;
  int tx_idle_pct   = 29;
  int rx_idle_pct   = 46;
  halt_kind_e end_kind;

  accumulator_stack_machine_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  asmc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_i      (s_axis_tready),
    .req_data_i       (s_axis_tdata),
    .req_user_i       (s_axis_tuser),
    .rsp_valid_i      (m_axis_tvalid),
    .rsp_ready_i      (m_axis_tready),
    .rsp_data_i       (m_axis_tdata),
    .rsp_user_i       (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding),
    .results_o        (results_seen),
    .writes_o         (writes_seen)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver backpressure, changed on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt, outstanding);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one request and holds it until the block takes it.
  task automatic send_item(input logic cmd, input logic [4:0] op, input logic [7:0] a,
                           input logic [7:0] b, input logic [7:0] tgt, input logic [31:0] dv);
    @(negedge clk_i);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, dv, tgt, b, a, op};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  // Instruction request with random filler in the fields it does not use.
  task automatic send_op(input logic [4:0] op, input logic [7:0] a);
    send_item(1'b0, op, a, 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic send_branch(input logic [4:0] op, input logic [7:0] tgt);
    send_item(1'b0, op, 8'($urandom), 8'($urandom), tgt, $urandom);
  endtask

  // Variable initialization request; the opcode bits are don't-care here.
  task automatic set_var(input logic [7:0] idx, input logic [31:0] value);
    send_item(1'b1, 5'($urandom), idx, 8'($urandom), 8'($urandom), value);
  endtask

  // Lowers valid and waits until every expected result has been taken.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Random data word, biased toward the corner values.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  // Any variable index except the two kept by the testbench.
  function automatic logic [7:0] pick_dest();
    logic [7:0] idx;
    do begin
      idx = 8'($urandom_range(0, 255));
    end while (idx == DIVISOR_VAR || idx == OFFSET_VAR);
    return idx;
  endfunction

  // Any instruction that can never stop the machine.
  task automatic send_plain();
    logic [4:0] op;
    logic [7:0] a;
    a = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 16))
      0:  op = OP_ADD;
      1:  op = OP_SUB;
      2:  op = OP_MULT;
      3:  op = OP_LOAD;
      4:  op = OP_STORE;
      5:  op = OP_COPY;
      6:  op = OP_READ;
      7:  op = OP_WRITE;
      8:  op = OP_NOOP;
      9:  op = OP_BR;
      10: op = OP_BRNEG;
      11: op = OP_BRZNEG;
      12: op = OP_BRPOS;
      13: op = OP_BRZPOS;
      14: op = OP_BRZERO;
      default: op = 5'($urandom_range(OP_STACKR + 1, OP_MAX_CODE));
    endcase
    if (op == OP_STORE || op == OP_COPY || op == OP_READ) begin
      a = pick_dest();
    end
    send_item(1'b0, op, a, 8'($urandom), 8'($urandom), rand_word());
  endtask

  // One random step: noise instructions or a well-formed divide or stack sequence.
  task automatic random_step();
    int          pick;
    logic [31:0] divisor;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_plain();
    end else if (pick < 60) begin
      set_var(pick_dest(), rand_word());
    end else if (pick < 70) begin
      divisor = ($urandom_range(0, 1) == 0) ? 32'($signed($urandom_range(1, 9)) *
                ($urandom_range(0, 1) ? 1 : -1)) : rand_word();
      if (divisor == '0) divisor = 32'd1;
      set_var(DIVISOR_VAR, divisor);
      send_op(OP_DIV, DIVISOR_VAR);
    end else if (pick < 82) begin
      if (stk_depth == 0 || (stk_depth < STACK_SOFT_CAP && $urandom_range(0, 1) == 0)) begin
        send_op(OP_PUSH, 8'($urandom));
        stk_depth++;
      end else begin
        send_op(OP_POP, 8'($urandom));
        stk_depth--;
      end
    end else if (stk_depth > 0) begin
      set_var(OFFSET_VAR, 32'($urandom_range(0, stk_depth - 1)));
      send_op(($urandom_range(0, 1) == 0) ? OP_STACKW : OP_STACKR, OFFSET_VAR);
    end else begin
      send_op(OP_PUSH, 8'($urandom));
      stk_depth++;
    end
  endtask

  // Main stimulus sequence.
  initial begin
    int random_start;

    // Reset, then the block runs its memory clearing pass with tready low.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: field extremes, every operation other than STOP, and the arithmetic corners.
    set_var(8'd1, 32'h7FFF_FFFF);
    set_var(8'd2, 32'h8000_0000);
    set_var(DIVISOR_VAR, 32'hFFFF_FFFF);
    send_op(OP_LOAD, 8'd2);
    send_branch(OP_BRNEG, 8'hFF);
    send_branch(OP_BRZNEG, 8'h00);
    // Most negative value divided by minus one wraps back to itself.
    send_op(OP_DIV, DIVISOR_VAR);
    send_op(OP_ADD, 8'd1);
    send_branch(OP_BRPOS, 8'h55);
    send_op(OP_SUB, 8'd1);
    send_op(OP_MULT, 8'd2);
    send_op(OP_WRITE, 8'd1);
    send_op(OP_STORE, 8'hFF);
    send_item(1'b0, OP_COPY, 8'h00, 8'hFF, 8'h00, 32'h0);
    send_item(1'b0, OP_READ, 8'd3, 8'h00, 8'hFF, 32'hFFFF_FFFF);
    // Zero accumulator takes the zero branches.
    send_op(OP_LOAD, 8'd4);
    send_branch(OP_BRZERO, 8'h80);
    send_branch(OP_BRZPOS, 8'h7F);
    send_branch(OP_BR, 8'h00);
    // Top of stack written and read back, then popped.
    send_op(OP_PUSH, 8'h00);
    set_var(OFFSET_VAR, 32'd0);
    send_op(OP_STACKW, OFFSET_VAR);
    send_op(OP_STACKR, OFFSET_VAR);
    send_op(OP_POP, 8'h00);
    send_op(OP_NOOP, 8'hFF);
    send_op(OP_MAX_CODE, 8'hAA);

    // Random part in three idling phases, draining completely between them.
    random_start = sent_count;
    while (sent_count < ITEM_GOAL) begin
      if (tx_idle_pct == 29 && sent_count >= random_start + (ITEM_GOAL - random_start) / 3) begin
        drain();
        tx_idle_pct = 46;
        rx_idle_pct = 29;
      end else if (tx_idle_pct == 46 &&
                   sent_count >= random_start + 2 * (ITEM_GOAL - random_start) / 3) begin
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_step();
    end
    random_count = sent_count - random_start;

    // Stop the machine once, in a way picked at random.
    end_kind = halt_kind_e'($urandom_range(END_STOP, END_DIV_ZERO));
    case (end_kind)
      END_STOP: begin
        send_op(OP_STOP, 8'($urandom));
      end
      END_UNDERFLOW: begin
        while (stk_depth > 0) begin
          send_op(OP_POP, 8'($urandom));
          stk_depth--;
        end
        send_op(OP_POP, 8'($urandom));
      end
      END_RANGE: begin
        // Either one past the bottom of the stack or a negative offset.
        set_var(OFFSET_VAR, ($urandom_range(0, 1) == 0) ? 32'(stk_depth) :
                32'($signed(-$urandom_range(1, 1000))));
        send_op(($urandom_range(0, 1) == 0) ? OP_STACKW : OP_STACKR, OFFSET_VAR);
      end
      default: begin
        set_var(DIVISOR_VAR, 32'd0);
        send_op(OP_DIV, DIVISOR_VAR);
      end
    endcase

    // After the halt every request must be ignored.
    repeat (POST_HALT_ITEMS) begin
      send_item(1'($urandom), 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
    end

    // Wait for the last results, then give stray results time to show up.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d random) and checked %0d results, %0d carrying WRITE data.",
             sent_count, random_count, results_seen, writes_seen);
    $display("The machine was stopped by %s, then %0d requests were sent to the halted core.",
             end_kind.name(), POST_HALT_ITEMS);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[accumulator_stack_machine_core.f]
hw/rtl/asmc_pkg.sv
hw/rtl/asmc_div.sv
hw/rtl/asmc_dpath.sv
hw/rtl/asmc_ctrl.sv
hw/rtl/accumulator_stack_machine_core.sv
tb/asmc_checker.sv
tb/tb_accumulator_stack_machine_core.sv
